// ===== rtl/core/segment_intersection_test_assert.svh =====
// Assertion helpers, clocked on clock and held off during reset.
`ifndef SEGMENT_INTERSECTION_TEST_ASSERT_SVH
`define SEGMENT_INTERSECTION_TEST_ASSERT_SVH

// Same-cycle implication.
`define SIS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SIS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/sis_pkg.sv =====
package sis_pkg;

   localparam int COORD_WIDTH = 16;

   // sign class of one cross product
   typedef enum logic [1:0] {
      ORIENT_COLLINEAR = 2'd0,
      ORIENT_POSITIVE  = 2'd1,
      ORIENT_NEGATIVE  = 2'd2
   } orient_type;

endpackage

// ===== rtl/core/sis_if.sv =====
interface sis_req_if #(
   parameter int COORD_WIDTH = sis_pkg::COORD_WIDTH
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] a_x;
   logic signed [COORD_WIDTH-1:0] a_y;
   logic signed [COORD_WIDTH-1:0] b_x;
   logic signed [COORD_WIDTH-1:0] b_y;
   logic signed [COORD_WIDTH-1:0] c_x;
   logic signed [COORD_WIDTH-1:0] c_y;
   logic signed [COORD_WIDTH-1:0] d_x;
   logic signed [COORD_WIDTH-1:0] d_y;

   modport source (output valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y, input ready);
   modport sink   (input valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y, output ready);
endinterface

interface sis_rsp_if;
   logic valid;
   logic ready;
   logic intersects;

   modport source (output valid, intersects, input ready);
   modport sink   (input valid, intersects, output ready);
endinterface

// ===== rtl/core/sis_delta.sv =====
// Stage 1: coordinate differences for the four cross products, plus the
// bounding-box tests used in the collinear case.
module sis_delta #(
   parameter int COORD_WIDTH = sis_pkg::COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          ld,
   input  logic signed [COORD_WIDTH-1:0] a_x,
   input  logic signed [COORD_WIDTH-1:0] a_y,
   input  logic signed [COORD_WIDTH-1:0] b_x,
   input  logic signed [COORD_WIDTH-1:0] b_y,
   input  logic signed [COORD_WIDTH-1:0] c_x,
   input  logic signed [COORD_WIDTH-1:0] c_y,
   input  logic signed [COORD_WIDTH-1:0] d_x,
   input  logic signed [COORD_WIDTH-1:0] d_y,
   output logic signed [COORD_WIDTH:0]   dqy_ff [4],
   output logic signed [COORD_WIDTH:0]   drx_ff [4],
   output logic signed [COORD_WIDTH:0]   dqx_ff [4],
   output logic signed [COORD_WIDTH:0]   dry_ff [4],
   output logic [3:0]                    box_ff
);

   localparam int DW = COORD_WIDTH + 1;

   logic signed [COORD_WIDTH-1:0] px [4];
   logic signed [COORD_WIDTH-1:0] py [4];
   logic signed [COORD_WIDTH-1:0] qx [4];
   logic signed [COORD_WIDTH-1:0] qy [4];
   logic signed [COORD_WIDTH-1:0] rx [4];
   logic signed [COORD_WIDTH-1:0] ry [4];
   logic signed [DW-1:0]          dqy_in [4];
   logic signed [DW-1:0]          drx_in [4];
   logic signed [DW-1:0]          dqx_in [4];
   logic signed [DW-1:0]          dry_in [4];
   logic [3:0]                    box_in;

   // p inside the box spanned by q and r, edges included
   function automatic logic in_box(
      input logic signed [COORD_WIDTH-1:0] p_x, p_y, q_x, q_y, r_x, r_y
   );
      in_box = (p_x <= q_x || p_x <= r_x) && (p_x >= q_x || p_x >= r_x) &&
               (p_y <= q_y || p_y <= r_y) && (p_y >= q_y || p_y >= r_y);
   endfunction

   // triplets (p,q,r): (a,c,b) (a,d,b) (c,a,d) (c,b,d)
   assign px = '{a_x, a_x, c_x, c_x};
   assign py = '{a_y, a_y, c_y, c_y};
   assign qx = '{c_x, d_x, a_x, b_x};
   assign qy = '{c_y, d_y, a_y, b_y};
   assign rx = '{b_x, b_x, d_x, d_x};
   assign ry = '{b_y, b_y, d_y, d_y};

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         dqy_in[i] = DW'(qy[i]) - DW'(py[i]);
         drx_in[i] = DW'(rx[i]) - DW'(qx[i]);
         dqx_in[i] = DW'(qx[i]) - DW'(px[i]);
         dry_in[i] = DW'(ry[i]) - DW'(qy[i]);
      end
      box_in[0] = in_box(c_x, c_y, a_x, a_y, b_x, b_y);
      box_in[1] = in_box(d_x, d_y, a_x, a_y, b_x, b_y);
      box_in[2] = in_box(a_x, a_y, c_x, c_y, d_x, d_y);
      box_in[3] = in_box(b_x, b_y, c_x, c_y, d_x, d_y);
   end

   always_ff @(posedge clock) begin
      if (ld) begin
         dqy_ff <= dqy_in;
         drx_ff <= drx_in;
         dqx_ff <= dqx_in;
         dry_ff <= dry_in;
         box_ff <= box_in;
      end
   end

endmodule

// ===== rtl/core/sis_mult.sv =====
// Stage 2: the two products of each cross product, exact width.
module sis_mult #(
   parameter int COORD_WIDTH = sis_pkg::COORD_WIDTH
) (
   input  logic                            clock,
   input  logic                            ld,
   input  logic signed [COORD_WIDTH:0]     dqy [4],
   input  logic signed [COORD_WIDTH:0]     drx [4],
   input  logic signed [COORD_WIDTH:0]     dqx [4],
   input  logic signed [COORD_WIDTH:0]     dry [4],
   output logic signed [2*COORD_WIDTH+1:0] lhs_ff [4],
   output logic signed [2*COORD_WIDTH+1:0] rhs_ff [4]
);

   localparam int PW = 2 * COORD_WIDTH + 2;

   logic signed [PW-1:0] lhs_in [4];
   logic signed [PW-1:0] rhs_in [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         lhs_in[i] = dqy[i] * drx[i];
         rhs_in[i] = dqx[i] * dry[i];
      end
   end

   always_ff @(posedge clock) begin
      if (ld) begin
         lhs_ff <= lhs_in;
         rhs_ff <= rhs_in;
      end
   end

endmodule

// ===== rtl/core/sis_orient.sv =====
// Stage 3: sign class of each cross product from an exact compare.
module sis_orient #(
   parameter int COORD_WIDTH = sis_pkg::COORD_WIDTH
) (
   input  logic                            clock,
   input  logic                            ld,
   input  logic signed [2*COORD_WIDTH+1:0] lhs [4],
   input  logic signed [2*COORD_WIDTH+1:0] rhs [4],
   output sis_pkg::orient_type             sign_ff [4]
);

   sis_pkg::orient_type sign_in [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         priority if (lhs[i] == rhs[i]) begin
            sign_in[i] = sis_pkg::ORIENT_COLLINEAR;
         end else if (lhs[i] > rhs[i]) begin
            sign_in[i] = sis_pkg::ORIENT_POSITIVE;
         end else begin
            sign_in[i] = sis_pkg::ORIENT_NEGATIVE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld) begin
         sign_ff <= sign_in;
      end
   end

endmodule

// ===== rtl/core/segment_intersection_test.sv =====
// Channel | Role   | Payload
// req_if  | sink   | a_x a_y b_x b_y c_x c_y d_x d_y, COORD_WIDTH bits signed each
// rsp_if  | source | intersects, 1 bit
//
// One transaction per cycle sustained while rsp_if.ready stays high; a request
// that is taken passes the stage registers in order before its response is valid.
// Four register stages set the depth: differences, products, compare, combine.
// Synchronous active-high reset clears the stage valid bits only.
// Each stage advances when it is empty or the stage after it advances, so a
// bubble is squeezed out and a stalled response holds without loss or repeat.
module segment_intersection_test #(
   parameter int COORD_WIDTH = sis_pkg::COORD_WIDTH
) (
   input logic       clock,
   input logic       reset,
   sis_req_if.sink   req_if,
   sis_rsp_if.source rsp_if
);

   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = 2 * COORD_WIDTH + 2;

   // stage valid bits
   logic v1_ff, v2_ff, v3_ff, vo_ff;
   // stage load enables
   logic ld1, ld2, ld3, ld4;

   logic signed [DW-1:0] dqy [4];
   logic signed [DW-1:0] drx [4];
   logic signed [DW-1:0] dqx [4];
   logic signed [DW-1:0] dry [4];
   logic [3:0]           box1;
   logic [3:0]           box2_ff, box3_ff;
   logic signed [PW-1:0] lhs [4];
   logic signed [PW-1:0] rhs [4];
   sis_pkg::orient_type  sgn [4];

   logic intersects_in;
   logic intersects_ff;

   // Enable chain from the output back to the input.
   assign ld4 = !vo_ff || rsp_if.ready;
   assign ld3 = !v3_ff || ld4;
   assign ld2 = !v2_ff || ld3;
   assign ld1 = !v1_ff || ld2;

   assign req_if.ready = ld1;

   // Stage 1: differences and box tests
   sis_delta #(.COORD_WIDTH(COORD_WIDTH)) u_delta (
      .clock (clock),
      .ld    (ld1),
      .a_x   (req_if.a_x),
      .a_y   (req_if.a_y),
      .b_x   (req_if.b_x),
      .b_y   (req_if.b_y),
      .c_x   (req_if.c_x),
      .c_y   (req_if.c_y),
      .d_x   (req_if.d_x),
      .d_y   (req_if.d_y),
      .dqy_ff(dqy),
      .drx_ff(drx),
      .dqx_ff(dqx),
      .dry_ff(dry),
      .box_ff(box1)
   );

   // Stage 2: products
   sis_mult #(.COORD_WIDTH(COORD_WIDTH)) u_mult (
      .clock (clock),
      .ld    (ld2),
      .dqy   (dqy),
      .drx   (drx),
      .dqx   (dqx),
      .dry   (dry),
      .lhs_ff(lhs),
      .rhs_ff(rhs)
   );

   // Stage 3: orientation classes
   sis_orient #(.COORD_WIDTH(COORD_WIDTH)) u_orient (
      .clock  (clock),
      .ld     (ld3),
      .lhs    (lhs),
      .rhs    (rhs),
      .sign_ff(sgn)
   );

   // Box bits ride alongside the arithmetic.
   always_ff @(posedge clock) begin
      if (ld2) begin
         box2_ff <= box1;
      end
      if (ld3) begin
         box3_ff <= box2_ff;
      end
   end

   // Proper crossing, or a collinear endpoint inside the other segment's box.
   // sgn[0]: C vs A-B, sgn[1]: D vs A-B, sgn[2]: A vs C-D, sgn[3]: B vs C-D.
   assign intersects_in = ((sgn[0] != sgn[1]) && (sgn[2] != sgn[3])) ||
                          ((sgn[0] == sis_pkg::ORIENT_COLLINEAR) && box3_ff[0]) ||
                          ((sgn[1] == sis_pkg::ORIENT_COLLINEAR) && box3_ff[1]) ||
                          ((sgn[2] == sis_pkg::ORIENT_COLLINEAR) && box3_ff[2]) ||
                          ((sgn[3] == sis_pkg::ORIENT_COLLINEAR) && box3_ff[3]);

   // Stage 4: output register
   always_ff @(posedge clock) begin
      if (ld4) begin
         intersects_ff <= intersects_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (ld1) begin
            v1_ff <= req_if.valid;
         end
         if (ld2) begin
            v2_ff <= v1_ff;
         end
         if (ld3) begin
            v3_ff <= v2_ff;
         end
         if (ld4) begin
            vo_ff <= v3_ff;
         end
      end
   end

   assign rsp_if.valid      = vo_ff;
   assign rsp_if.intersects = intersects_ff;

endmodule

// ===== rtl/core/sis_checker.sv =====
`include "segment_intersection_test_assert.svh"

module sis_checker #(
   parameter int COORD_WIDTH = sis_pkg::COORD_WIDTH
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic signed [COORD_WIDTH-1:0] a_x,
   input logic signed [COORD_WIDTH-1:0] a_y,
   input logic signed [COORD_WIDTH-1:0] c_x,
   input logic signed [COORD_WIDTH-1:0] c_y,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          intersects
);

   logic req_acc;
   logic shared_pt;
   logic rsp_stall;
   logic rsp_hit;

   assign req_acc   = req_valid && req_ready;
   assign shared_pt = req_acc && (a_x == c_x) && (a_y == c_y);
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_hit   = rsp_valid && intersects;

   `SIS_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid, "response dropped while stalled")

   `SIS_ASSERT_NEXT(a_rsp_stable, rsp_stall, $stable(intersects), "stalled response changed")

   `SIS_ASSERT_NEXT(a_latency, req_acc ##1 rsp_ready [*3], rsp_valid, "response late")

   `SIS_ASSERT_NEXT(a_shared_point, shared_pt ##1 rsp_ready [*3], rsp_hit, "shared end missed")

endmodule

bind segment_intersection_test sis_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sis_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .a_x       (req_if.a_x),
   .a_y       (req_if.a_y),
   .c_x       (req_if.c_x),
   .c_y       (req_if.c_y),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .intersects(rsp_if.intersects)
);

// ===== sim/tb_top.sv =====
module tb_top;

   localparam int W = sis_pkg::COORD_WIDTH;

   // Cycles with no transaction on either channel before the run is declared hung.
   // The receiver stalls 87% of the time in one phase, so runs of dead cycles are
   // normal there.
   localparam int unsigned HANG_LIMIT = 1000;

   // Pipeline is 4 deep; give the tail extra cycles to show stray responses.
   localparam int unsigned DRAIN_CYCLES = 8;

   typedef logic signed [W-1:0] coord_type;

   localparam coord_type COORD_MAX = {1'b0, {(W-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(W-1){1'b0}}};

   typedef struct {
      coord_type x;
      coord_type y;
   } point_type;

   typedef struct {
      point_type a;
      point_type b;
      point_type c;
      point_type d;
   } seg_pair_type;

   // One outstanding request and the verdict it should produce.
   typedef struct {
      seg_pair_type pair;
      bit           hit;
   } pending_type;

   logic clock;
   logic reset;

   sis_req_if #(.COORD_WIDTH(W)) req_if ();
   sis_rsp_if                    rsp_if ();

   segment_intersection_test #(.COORD_WIDTH(W)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   pending_type pending_hits[$];
   int unsigned fail_count = 0;
   int unsigned idle_cycles = 0;
   int unsigned req_gap_pct;
   int unsigned rsp_stall_pct;
   pending_type oldest;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Golden geometry
   // ------------------------------------------------------------------

   // Sign of the cross product for the triplet (p, q, r). Differences are one bit
   // wider than a coordinate and products twice that, so the compare is exact
   // even with every coordinate at an extreme.
   function automatic sis_pkg::orient_type cross_sign(point_type p, point_type q,
                                                      point_type r);
      logic signed [W:0]     dqy;
      logic signed [W:0]     drx;
      logic signed [W:0]     dqx;
      logic signed [W:0]     dry;
      logic signed [2*W+1:0] lhs;
      logic signed [2*W+1:0] rhs;
      dqy = q.y - p.y;
      drx = r.x - q.x;
      dqx = q.x - p.x;
      dry = r.y - q.y;
      lhs = dqy * drx;
      rhs = dqx * dry;
      if (lhs == rhs) return sis_pkg::ORIENT_COLLINEAR;
      return (lhs > rhs) ? sis_pkg::ORIENT_POSITIVE : sis_pkg::ORIENT_NEGATIVE;
   endfunction

   // p inside the closed bounding box of q and r; both axes use q and r.
   function automatic bit in_box(point_type p, point_type q, point_type r);
      return (p.x <= q.x || p.x <= r.x) && (p.x >= q.x || p.x >= r.x) &&
             (p.y <= q.y || p.y <= r.y) && (p.y >= q.y || p.y >= r.y);
   endfunction

   function automatic bit segments_touch(seg_pair_type s);
      sis_pkg::orient_type s1;
      sis_pkg::orient_type s2;
      sis_pkg::orient_type s3;
      sis_pkg::orient_type s4;
      bit                  hit;
      s1  = cross_sign(s.a, s.c, s.b);
      s2  = cross_sign(s.a, s.d, s.b);
      s3  = cross_sign(s.c, s.a, s.d);
      s4  = cross_sign(s.c, s.b, s.d);
      // proper crossing: each segment splits the other's endpoints
      hit = (s1 != s2) && (s3 != s4);
      // collinear endpoint lying within the other segment
      if (!hit && s1 == sis_pkg::ORIENT_COLLINEAR && in_box(s.c, s.a, s.b)) hit = 1'b1;
      if (!hit && s2 == sis_pkg::ORIENT_COLLINEAR && in_box(s.d, s.a, s.b)) hit = 1'b1;
      if (!hit && s3 == sis_pkg::ORIENT_COLLINEAR && in_box(s.a, s.c, s.d)) hit = 1'b1;
      if (!hit && s4 == sis_pkg::ORIENT_COLLINEAR && in_box(s.b, s.c, s.d)) hit = 1'b1;
      return hit;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   function automatic point_type pt(int x, int y);
      point_type p;
      p.x = coord_type'(x);
      p.y = coord_type'(y);
      return p;
   endfunction

   function automatic coord_type any_coord();
      return coord_type'($urandom);
   endfunction

   // Values around the two's complement limits and zero.
   function automatic coord_type corner_coord();
      case ($urandom_range(6))
         0: return COORD_MIN;
         1: return COORD_MIN + coord_type'(1);
         2: return coord_type'(-1);
         3: return coord_type'(0);
         4: return coord_type'(1);
         5: return COORD_MAX - coord_type'(1);
         default: return COORD_MAX;
      endcase
   endfunction

   function automatic point_type corner_point();
      point_type p;
      p.x = corner_coord();
      p.y = corner_coord();
      return p;
   endfunction

   function automatic point_type any_point();
      point_type p;
      p.x = any_coord();
      p.y = any_coord();
      return p;
   endfunction

   // Called and returns at a falling edge. Gaps drop valid for whole cycles;
   // back-to-back transactions keep valid high without touching it twice.
   task automatic drive_pair(point_type a, point_type b, point_type c, point_type d);
      pending_type item;
      item.pair.a = a;
      item.pair.b = b;
      item.pair.c = c;
      item.pair.d = d;
      item.hit    = segments_touch(item.pair);
      while ($urandom_range(99) < req_gap_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.a_x   <= a.x;
      req_if.a_y   <= a.y;
      req_if.b_x   <= b.x;
      req_if.b_y   <= b.y;
      req_if.c_x   <= c.x;
      req_if.c_y   <= c.y;
      req_if.d_x   <= d.x;
      req_if.d_y   <= d.y;
      do @(posedge clock); while (!req_if.ready);
      pending_hits.insert(pending_hits.size(), item);
      @(negedge clock);
   endtask

   task automatic log_failure(string msg);
      fail_count++;
      if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
   endtask

   // ------------------------------------------------------------------
   // Directed tests
   // ------------------------------------------------------------------

   // Full-range diagonals: the widest differences and products the block sees.
   task automatic test_extremes();
      drive_pair(pt(-32768, -32768), pt(32767, 32767), pt(-32768, 32767), pt(32767, -32768));
      drive_pair(pt(-32768, 32767), pt(32767, -32768), pt(-32768, -32768), pt(32767, 32767));
      // parallel diagonals one unit apart, must not meet
      drive_pair(pt(-32768, -32768), pt(32767, 32767), pt(-32768, -32767), pt(32766, 32767));
      // reversed full-width horizontal overlapping itself
      drive_pair(pt(-32768, 0), pt(32767, 0), pt(32767, 0), pt(-32768, 0));
      // the origin sits on the long diagonal
      drive_pair(pt(-32768, -32768), pt(32767, 32767), pt(0, 0), pt(1, 0));
      drive_pair(pt(-32768, -32768), pt(32767, 32767), pt(1, 0), pt(2, 0));
   endtask

   // Collinear pairs: the bounding box decides, on both axes.
   task automatic test_collinear();
      drive_pair(pt(0, 0), pt(10, 10), pt(5, 5), pt(20, 20));
      drive_pair(pt(0, 0), pt(4, 4), pt(5, 5), pt(9, 9));
      drive_pair(pt(0, 0), pt(5, 5), pt(5, 5), pt(9, 9));
      // vertical: x matches everywhere, only the y range decides
      drive_pair(pt(7, 0), pt(7, 5), pt(7, 6), pt(7, 9));
      drive_pair(pt(7, 5), pt(7, 0), pt(7, -3), pt(7, 2));
      drive_pair(pt(0, 2), pt(5, 2), pt(6, 2), pt(9, 2));
   endtask

   // Shared endpoints and T-junctions.
   task automatic test_touching();
      drive_pair(pt(0, 0), pt(5, 0), pt(5, 0), pt(5, 7));
      drive_pair(pt(0, 0), pt(10, 0), pt(5, 0), pt(5, 9));
      drive_pair(pt(0, 0), pt(10, 0), pt(5, 1), pt(5, 9));
      drive_pair(pt(-3, 4), pt(3, -4), pt(-3, -4), pt(3, 4));
   endtask

   // Zero-length segments are points and follow the same rules.
   task automatic test_degenerate();
      drive_pair(pt(0, 0), pt(0, 0), pt(0, 0), pt(0, 0));
      drive_pair(pt(3, 3), pt(3, 3), pt(0, 0), pt(6, 6));
      drive_pair(pt(3, 4), pt(3, 4), pt(0, 0), pt(6, 6));
      drive_pair(pt(32767, -32768), pt(32767, -32768), pt(32767, -32768), pt(32767, -32768));
      drive_pair(pt(32767, -32768), pt(32767, -32768), pt(-32768, 32767), pt(-32768, 32767));
   endtask

   // ------------------------------------------------------------------
   // Random test
   // ------------------------------------------------------------------

   // Uniform coordinates almost never line up, so most pairs are built to be
   // collinear, share points, sit on a tiny grid, or hug the limits.
   task automatic test_random(int unsigned count);
      point_type   p[4];
      point_type   base;
      point_type   pool[3];
      int          dir_x;
      int          dir_y;
      int          span;
      int          k;
      int unsigned kind;
      repeat (count) begin
         kind = $urandom_range(99);
         if (kind < 25) begin
            foreach (p[i]) p[i] = any_point();
         end else if (kind < 50) begin
            // small grid: lots of collinear, touching and overlapping cases
            foreach (p[i]) p[i] = pt(int'($urandom_range(6)) - 3, int'($urandom_range(6)) - 3);
         end else if (kind < 70) begin
            // four points on one line, random order and spacing
            span  = $urandom_range(1) ? 3 : 2000;
            base  = pt(int'($urandom_range(32000)) - 16000, int'($urandom_range(32000)) - 16000);
            dir_x = int'($urandom_range(2 * span)) - span;
            dir_y = int'($urandom_range(2 * span)) - span;
            foreach (p[i]) begin
               k    = int'($urandom_range(16)) - 8;
               p[i] = pt(base.x + k * dir_x, base.y + k * dir_y);
            end
         end else if (kind < 85) begin
            // endpoints drawn from three points: shared ends and point segments
            foreach (pool[i]) pool[i] = any_point();
            foreach (p[i]) p[i] = pool[$urandom_range(2)];
         end else begin
            foreach (p[i]) p[i] = corner_point();
         end
         drive_pair(p[0], p[1], p[2], p[3]);
      end
   endtask

   // ------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_hits.size() == 0) begin
            log_failure($sformatf("response with nothing outstanding, intersects=%b",
                                  rsp_if.intersects));
         end else begin
            oldest = pending_hits.pop_front();
            if (rsp_if.intersects !== oldest.hit)
               log_failure($sformatf(
                  "intersects exp %b got %b for A(%0d,%0d) B(%0d,%0d) C(%0d,%0d) D(%0d,%0d)",
                  oldest.hit, rsp_if.intersects,
                  oldest.pair.a.x, oldest.pair.a.y, oldest.pair.b.x, oldest.pair.b.y,
                  oldest.pair.c.x, oldest.pair.c.y, oldest.pair.d.x, oldest.pair.d.y));
         end
      end
   end

   // Hang detector: counts cycles with no transaction on either channel.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= HANG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      req_gap_pct   = 34;
      rsp_stall_pct = 87;
      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.a_x    = '0;
      req_if.a_y    = '0;
      req_if.b_x    = '0;
      req_if.b_y    = '0;
      req_if.c_x    = '0;
      req_if.c_y    = '0;
      req_if.d_x    = '0;
      req_if.d_y    = '0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // phase 1: sender gaps sometimes, receiver stalls mostly
      test_extremes();
      test_collinear();
      test_touching();
      test_degenerate();
      test_random(633);

      // phase 2: roles swapped
      req_gap_pct   = 87;
      rsp_stall_pct = 34;
      test_random(633);

      // phase 3: full rate both ways
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      test_random(634);

      req_if.valid <= 1'b0;

      // drain; the hang detector covers a response that never comes
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
